@@ hw/rtl/rgd_pkg.sv @@
package rgd_pkg;

    localparam int BLOCK_W    = 16;
    localparam int COUNTRY_W  = 4;
    localparam int KIND_W     = 2;
    localparam int NAME_W     = 64;
    localparam int CHUNK_W    = 3;
    localparam int HOURS_W    = 11;
    localparam int MINUTES_W  = 6;
    localparam int TEXT_IDX_W = 6;
    localparam int TEXT_ROWS  = 8;
    localparam int HALF_W     = 32;

    localparam logic [COUNTRY_W-1:0] COUNTRY_RESET = 4'd3;
    localparam logic [NAME_W-1:0]    NAME_RESET    = {8{8'h2D}};

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAME   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIME   = 2'd3;

    localparam logic [3:0] GTYPE_NAME = 4'h0;
    localparam logic [3:0] GTYPE_TEXT = 4'h2;
    localparam logic [3:0] GTYPE_TIME = 4'h4;

    localparam logic [1:0]         NAME_LAST_SEG = 2'd3;
    localparam logic [CHUNK_W-1:0] LAST_CHUNK    = 3'd7;

    // reciprocal of 60 scaled by 2^21, exact for every 16-bit count
    localparam logic [BLOCK_W-1:0] RECIP_60    = 16'h8889;
    localparam int                 RECIP_SHIFT = 21;

    typedef enum logic [2:0] {
        CMD_INVALID,
        CMD_RESET,
        CMD_NAME,
        CMD_TEXT,
        CMD_TIME,
        CMD_OTHER
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TIME,
        ST_TEXT
    } state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [1:0]         seg;
        logic [3:0]         text_pos;
        logic               ab_flag;
        logic [HALF_W-1:0]  chars;
        logic [BLOCK_W-1:0] minute_count;
    } cmd_t;

endpackage

@@ hw/rtl/rgd_group_if.sv @@
interface rgd_group_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_a;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;

    modport source (output valid, output block_a, output block_b, output block_c,
                    output block_d, input ready);
    modport sink (input valid, input block_a, input block_b, input block_c,
                  input block_d, output ready);
endinterface

@@ hw/rtl/rgd_result_if.sv @@
interface rgd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        group_valid;
    logic [63:0] station_name;
    logic [63:0] text_chars;
    logic [2:0]  chunk_index;
    logic [10:0] hours;
    logic [5:0]  minutes;
    logic        last_of_run;

    modport source (output valid, output result_kind, output group_valid,
                    output station_name, output text_chars, output chunk_index,
                    output hours, output minutes, output last_of_run, input ready);
    modport sink (input valid, input result_kind, input group_valid,
                  input station_name, input text_chars, input chunk_index,
                  input hours, input minutes, input last_of_run, output ready);
endinterface

@@ hw/rtl/rgd_queue.sv @@
module rgd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rgd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rgd_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgd_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/rgd_front.sv @@
module rgd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    rgd_group_if.sink                       grp,
    input  logic                            cfg_we,
    input  logic [rgd_pkg::COUNTRY_W-1:0]   cfg_wdata,
    input  logic                            q_full,
    output logic                            push,
    output rgd_pkg::cmd_t                   cmd
);

    logic [rgd_pkg::COUNTRY_W-1:0] country_reg;
    logic [rgd_pkg::COUNTRY_W-1:0] country_next;
    logic                          version;
    logic                          group_ok;
    logic [15:0]                   hour16;
    logic [15:0]                   off16;
    logic [15:0]                   base16;
    logic [15:0]                   off_min;

    assign grp.ready = !q_full;
    assign push      = grp.valid && !q_full;

    assign country_next = cfg_we ? cfg_wdata : country_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            country_reg <= rgd_pkg::COUNTRY_RESET;
        end
        else
        begin
            country_reg <= country_next;
        end
    end

    assign version  = grp.block_b[11];
    assign group_ok = (grp.block_a[15:12] == country_reg)
                      && (!version || (grp.block_a == grp.block_c));

    // local minute count, 16-bit wrap
    assign hour16  = 16'({grp.block_c[0], grp.block_d[15:12]});
    assign off16   = 16'(grp.block_d[4:0]);
    assign base16  = 16'(grp.block_d[11:6]) + ((hour16 << 6) - (hour16 << 2));
    assign off_min = (off16 << 5) - (off16 << 1);

    always_comb
    begin
        cmd.seg          = grp.block_b[1:0];
        cmd.text_pos     = grp.block_b[3:0];
        cmd.ab_flag      = grp.block_b[4];
        cmd.chars        = {grp.block_c, grp.block_d};
        cmd.minute_count = grp.block_d[5] ? (base16 - off_min) : (base16 + off_min);
        if (!group_ok)
        begin
            cmd.kind = rgd_pkg::CMD_INVALID;
        end
        else if (grp.block_a == '0)
        begin
            cmd.kind = rgd_pkg::CMD_RESET;
        end
        else if (grp.block_b[15:12] == rgd_pkg::GTYPE_NAME)
        begin
            cmd.kind = rgd_pkg::CMD_NAME;
        end
        else if (version)
        begin
            cmd.kind = rgd_pkg::CMD_OTHER;
        end
        else
        begin
            unique case (grp.block_b[15:12])
                rgd_pkg::GTYPE_TEXT: cmd.kind = rgd_pkg::CMD_TEXT;
                rgd_pkg::GTYPE_TIME: cmd.kind = rgd_pkg::CMD_TIME;
                default:             cmd.kind = rgd_pkg::CMD_OTHER;
            endcase
        end
    end

endmodule

@@ hw/rtl/rgd_back.sv @@
module rgd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rgd_pkg::cmd_t q_cmd,
    output logic          pop,
    rgd_result_if.source  res
);

    localparam int ROW_W = $clog2(rgd_pkg::TEXT_ROWS);

    rgd_pkg::state_t state_reg;
    rgd_pkg::state_t state_next;

    logic [rgd_pkg::CHUNK_W-1:0]    cnt_reg;
    logic [rgd_pkg::CHUNK_W-1:0]    cnt_next;
    logic [rgd_pkg::NAME_W-1:0]     name_reg;
    logic [rgd_pkg::NAME_W-1:0]     name_next;
    logic [rgd_pkg::HALF_W-1:0]     text_hi_reg [rgd_pkg::TEXT_ROWS];
    logic [rgd_pkg::HALF_W-1:0]     text_lo_reg [rgd_pkg::TEXT_ROWS];
    logic [rgd_pkg::TEXT_ROWS-1:0]  hi_vld_reg;
    logic [rgd_pkg::TEXT_ROWS-1:0]  hi_vld_next;
    logic [rgd_pkg::TEXT_ROWS-1:0]  lo_vld_reg;
    logic [rgd_pkg::TEXT_ROWS-1:0]  lo_vld_next;
    logic [rgd_pkg::TEXT_IDX_W-1:0] last_idx_reg;
    logic [rgd_pkg::TEXT_IDX_W-1:0] last_idx_next;
    logic                           ab_reg;
    logic                           ab_next;
    logic [15:0]                    minute_reg;
    logic [15:0]                    minute_next;
    logic [31:0]                    prod_reg;

    logic                           res_vld_reg;
    logic                           res_vld_next;
    logic [rgd_pkg::KIND_W-1:0]     kind_reg;
    logic                           gvalid_reg;
    logic [rgd_pkg::NAME_W-1:0]     sname_reg;
    logic [rgd_pkg::NAME_W-1:0]     tchars_reg;
    logic [rgd_pkg::CHUNK_W-1:0]    chunk_reg;
    logic [rgd_pkg::HOURS_W-1:0]    hours_reg;
    logic [rgd_pkg::MINUTES_W-1:0]  minutes_reg;
    logic                           last_reg;

    logic                           can_load;
    logic                           load;
    logic [rgd_pkg::KIND_W-1:0]     ld_kind;
    logic                           ld_gvalid;
    logic [rgd_pkg::NAME_W-1:0]     ld_sname;
    logic [rgd_pkg::NAME_W-1:0]     ld_tchars;
    logic [rgd_pkg::CHUNK_W-1:0]    ld_chunk;
    logic [rgd_pkg::HOURS_W-1:0]    ld_hours;
    logic [rgd_pkg::MINUTES_W-1:0]  ld_minutes;
    logic                           ld_last;

    logic                           do_clear;
    logic                           do_text_wr;
    logic                           text_we_hi;
    logic                           text_we_lo;
    logic [ROW_W-1:0]               wr_row;
    logic                           pub_needed;
    logic [rgd_pkg::NAME_W-1:0]     name_merged;
    logic [rgd_pkg::NAME_W-1:0]     chunk_word;
    logic [15:0]                    q16;
    logic [15:0]                    rem16;

    assign can_load   = !res_vld_reg || res.ready;
    assign pub_needed = ({q_cmd.text_pos, 2'b00} < last_idx_reg);
    assign wr_row     = q_cmd.text_pos[3:1];
    assign text_we_hi = do_text_wr && !q_cmd.text_pos[0];
    assign text_we_lo = do_text_wr && q_cmd.text_pos[0];

    assign chunk_word = {hi_vld_reg[cnt_reg] ? text_hi_reg[cnt_reg] : '0,
                         lo_vld_reg[cnt_reg] ? text_lo_reg[cnt_reg] : '0};

    assign q16   = 16'(prod_reg[rgd_pkg::RECIP_SHIFT +: rgd_pkg::HOURS_W]);
    assign rem16 = q_cmd.minute_count - ((q16 << 6) - (q16 << 2));

    always_comb
    begin
        case (q_cmd.seg)
            2'd0:    name_merged = {q_cmd.chars[15:0], name_reg[47:0]};
            2'd1:    name_merged = {name_reg[63:48], q_cmd.chars[15:0], name_reg[31:0]};
            2'd2:    name_merged = {name_reg[63:32], q_cmd.chars[15:0], name_reg[15:0]};
            default: name_merged = {name_reg[63:16], q_cmd.chars[15:0]};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgd_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == rgd_pkg::CMD_RESET && can_load)
                    begin
                        state_next = rgd_pkg::ST_TEXT;
                    end
                    else if (q_cmd.kind == rgd_pkg::CMD_TEXT && pub_needed)
                    begin
                        state_next = rgd_pkg::ST_TEXT;
                    end
                    else if (q_cmd.kind == rgd_pkg::CMD_TIME
                             && q_cmd.minute_count != minute_reg)
                    begin
                        state_next = rgd_pkg::ST_TIME;
                    end
                end
            end
            rgd_pkg::ST_TIME:
            begin
                if (can_load)
                begin
                    state_next = rgd_pkg::ST_IDLE;
                end
            end
            rgd_pkg::ST_TEXT:
            begin
                if (can_load && cnt_reg == rgd_pkg::LAST_CHUNK)
                begin
                    state_next = rgd_pkg::ST_IDLE;
                end
            end
            default: state_next = rgd_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        pop         = 1'b0;
        load        = 1'b0;
        ld_kind     = rgd_pkg::KIND_STATUS;
        ld_gvalid   = 1'b0;
        ld_sname    = '0;
        ld_tchars   = '0;
        ld_chunk    = '0;
        ld_hours    = '0;
        ld_minutes  = '0;
        ld_last     = 1'b1;
        do_clear    = 1'b0;
        do_text_wr  = 1'b0;
        cnt_next    = cnt_reg;
        name_next   = name_reg;
        minute_next = minute_reg;
        unique case (state_reg)
            rgd_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        rgd_pkg::CMD_INVALID:
                        begin
                            if (can_load)
                            begin
                                load = 1'b1;
                                pop  = 1'b1;
                            end
                        end
                        rgd_pkg::CMD_RESET:
                        begin
                            if (can_load)
                            begin
                                load      = 1'b1;
                                ld_kind   = rgd_pkg::KIND_NAME;
                                ld_sname  = rgd_pkg::NAME_RESET;
                                ld_last   = 1'b0;
                                do_clear  = 1'b1;
                                name_next = rgd_pkg::NAME_RESET;
                            end
                        end
                        rgd_pkg::CMD_NAME:
                        begin
                            if (can_load)
                            begin
                                load      = 1'b1;
                                pop       = 1'b1;
                                ld_gvalid = 1'b1;
                                name_next = name_merged;
                                if (q_cmd.seg == rgd_pkg::NAME_LAST_SEG)
                                begin
                                    ld_kind  = rgd_pkg::KIND_NAME;
                                    ld_sname = name_merged;
                                end
                            end
                        end
                        rgd_pkg::CMD_TEXT:
                        begin
                            if (!pub_needed && can_load)
                            begin
                                load       = 1'b1;
                                pop        = 1'b1;
                                ld_gvalid  = 1'b1;
                                do_text_wr = 1'b1;
                            end
                        end
                        rgd_pkg::CMD_TIME:
                        begin
                            if (q_cmd.minute_count != minute_reg)
                            begin
                                minute_next = q_cmd.minute_count;
                            end
                            else if (can_load)
                            begin
                                load      = 1'b1;
                                pop       = 1'b1;
                                ld_gvalid = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (can_load)
                            begin
                                load      = 1'b1;
                                pop       = 1'b1;
                                ld_gvalid = 1'b1;
                            end
                        end
                    endcase
                end
            end
            rgd_pkg::ST_TIME:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    pop        = 1'b1;
                    ld_kind    = rgd_pkg::KIND_TIME;
                    ld_gvalid  = 1'b1;
                    ld_hours   = q16[rgd_pkg::HOURS_W-1:0];
                    ld_minutes = rem16[rgd_pkg::MINUTES_W-1:0];
                end
            end
            rgd_pkg::ST_TEXT:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    ld_kind   = rgd_pkg::KIND_TEXT;
                    ld_gvalid = (q_cmd.kind == rgd_pkg::CMD_TEXT);
                    ld_tchars = chunk_word;
                    ld_chunk  = cnt_reg;
                    ld_last   = (cnt_reg == rgd_pkg::LAST_CHUNK);
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == rgd_pkg::LAST_CHUNK)
                    begin
                        pop        = 1'b1;
                        do_text_wr = (q_cmd.kind == rgd_pkg::CMD_TEXT);
                    end
                end
            end
            default: ;
        endcase
    end

    // text store bookkeeping
    always_comb
    begin
        hi_vld_next   = hi_vld_reg;
        lo_vld_next   = lo_vld_reg;
        last_idx_next = last_idx_reg;
        ab_next       = ab_reg;
        if (do_clear)
        begin
            hi_vld_next   = '0;
            lo_vld_next   = '0;
            last_idx_next = '0;
        end
        else if (do_text_wr)
        begin
            // a/b toggle wipes the text before the new characters land
            if (q_cmd.ab_flag != ab_reg)
            begin
                hi_vld_next = '0;
                lo_vld_next = '0;
            end
            if (q_cmd.text_pos[0])
            begin
                lo_vld_next[wr_row] = 1'b1;
            end
            else
            begin
                hi_vld_next[wr_row] = 1'b1;
            end
            last_idx_next = {q_cmd.text_pos, 2'b00};
            ab_next       = q_cmd.ab_flag;
        end
    end

    assign res_vld_next = load ? 1'b1 : (res.ready ? 1'b0 : res_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rgd_pkg::ST_IDLE;
            cnt_reg      <= '0;
            name_reg     <= rgd_pkg::NAME_RESET;
            hi_vld_reg   <= '0;
            lo_vld_reg   <= '0;
            last_idx_reg <= '0;
            ab_reg       <= 1'b0;
            minute_reg   <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            name_reg     <= name_next;
            hi_vld_reg   <= hi_vld_next;
            lo_vld_reg   <= lo_vld_next;
            last_idx_reg <= last_idx_next;
            ab_reg       <= ab_next;
            minute_reg   <= minute_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {16'b0, q_cmd.minute_count} * {16'b0, rgd_pkg::RECIP_60};
        if (text_we_hi)
        begin
            text_hi_reg[wr_row] <= q_cmd.chars;
        end
        if (text_we_lo)
        begin
            text_lo_reg[wr_row] <= q_cmd.chars;
        end
        if (load)
        begin
            kind_reg    <= ld_kind;
            gvalid_reg  <= ld_gvalid;
            sname_reg   <= ld_sname;
            tchars_reg  <= ld_tchars;
            chunk_reg   <= ld_chunk;
            hours_reg   <= ld_hours;
            minutes_reg <= ld_minutes;
            last_reg    <= ld_last;
        end
    end

    assign res.valid        = res_vld_reg;
    assign res.result_kind  = kind_reg;
    assign res.group_valid  = gvalid_reg;
    assign res.station_name = sname_reg;
    assign res.text_chars   = tchars_reg;
    assign res.chunk_index  = chunk_reg;
    assign res.hours        = hours_reg;
    assign res.minutes      = minutes_reg;
    assign res.last_of_run  = last_reg;

endmodule

@@ hw/rtl/rds_group_decoder.sv @@
// path: a group is registered in the command queue, then the back unit registers its result
//   beat; a changed time passes through ST_TIME first, a text publication through ST_TEXT
// throughput: the back unit emits at most one beat per cycle; a group yields one beat, a text
//   publication 8 chunk beats, and a block A of zero a name beat and then 8 chunk beats
// the front takes a group every cycle while the command queue has room
// reset: asynchronous, active low; country code 3, name all dashes, text empty, no clear pass
module rds_group_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rgd_group_if.sink                     grp,
    rgd_result_if.source                  res,
    input  logic                          cfg_we,
    input  logic [rgd_pkg::COUNTRY_W-1:0] cfg_wdata
);

    rgd_pkg::cmd_t push_cmd;
    rgd_pkg::cmd_t head_cmd;
    logic          push;
    logic          q_full;
    logic          pop;
    logic          head_valid;

    rgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    rgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rgd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_cmd   (head_cmd),
        .pop     (pop),
        .res     (res)
    );

endmodule
